// File: design/stlb_pkg.sv
// Shared types and constants of the server table load balancer.
package stlb_pkg;

   localparam int OpWidth = 3;
   localparam int IdWidth = 16;
   localparam int ChanWidth = 8;
   localparam int LoadWidth = 10;
   localparam int CpuWidth = 7;
   localparam int StatusWidth = 2;
   localparam int CodeWidth = 2;
   localparam int TimeWidth = 32;
   localparam int TimeoutWidth = 16;
   localparam int PolicyWidth = 2;

   typedef enum logic [OpWidth-1:0] {
      OP_SELECT     = 3'd0,
      OP_REGISTER   = 3'd1,
      OP_UNREGISTER = 3'd2,
      OP_UPDATE     = 3'd3,
      OP_SET_STATUS = 3'd4,
      OP_ASSIGN     = 3'd5,
      OP_RELEASE    = 3'd6,
      OP_TICK       = 3'd7
   } op_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_ONLINE     = 2'd0,
      ST_OFFLINE    = 2'd1,
      ST_MAINT      = 2'd2,
      ST_OVERLOADED = 2'd3
   } status_type;

   typedef enum logic [CodeWidth-1:0] {
      RC_OK       = 2'd0,
      RC_NONE     = 2'd1,
      RC_FULL     = 2'd2,
      RC_RESERVED = 2'd3
   } code_type;

   localparam logic [PolicyWidth-1:0] POL_ROUND_ROBIN = 2'd0;
   localparam logic [PolicyWidth-1:0] POL_CHANNEL     = 2'd2;

   localparam logic [1:0] CSR_POLICY   = 2'd0;
   localparam logic [1:0] CSR_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT  = 2'd2;
   localparam logic [1:0] CSR_CPU      = 2'd3;

   // One table row as stored in the memory.
   typedef struct packed {
      logic [IdWidth-1:0]   srv_id;
      logic [ChanWidth-1:0] channel;
      status_type           status;
      logic [LoadWidth-1:0] load;
      logic [LoadWidth-1:0] capacity;
      logic [TimeWidth-1:0] heartbeat;
   } entry_type;

endpackage

// File: design/server_table_load_balancer_core.sv
// Top level: server table in one memory, walked by a read-modify-write sequencer.
//
//  channel | direction | beat content
//  req_    | in        | tdata = operation, server id, channel, players, cpu, new_status
//  rsp_    | out       | tdata = chosen_server, result_code
//  csr_    | in        | wen, index, wdata (register write, no read-back)
//
// Every request but register walks the table one slot a cycle through the single memory
// read port; select in channel mode may walk it twice, the second time over all rows.
// Round robin first folds a rotation pointer left past the end back into the table,
// one table size at a time. Unregister compacts in the same pass.
// Reset is synchronous: it clears count, rotation pointer and time and sets the
// registers to their defaults; the memory needs no clearing. The response waits in
// an output register; the next request is taken only after it leaves.
module server_table_load_balancer_core #(
   parameter int TABLE_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] operation, [18:3] server id, [26:19] channel, [36:27] players,
   // [43:37] cpu_percent, [45:44] new_status, [47:46] zero
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [15:0] chosen_server, [17:16] result_code, [23:18] zero
   output logic [23:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import stlb_pkg::*;

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_READ  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FIN   = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   entry_type mem [TABLE_SLOTS];
   entry_type rd_q;

   state_type state_ff, state_in;
   logic [PolicyWidth-1:0] policy_ff;
   logic [LoadWidth-1:0] cap_ff;
   logic [TimeoutWidth-1:0] timeout_ff;
   logic [CpuWidth-1:0] cpuovl_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [IW-1:0] rot_ff, rot_in;
   logic [TimeWidth-1:0] time_ff, time_in;

   op_type op_ff;
   logic [IdWidth-1:0] id_ff;
   logic [ChanWidth-1:0] ch_ff;
   logic [LoadWidth-1:0] pc_ff;
   logic [CpuWidth-1:0] cpu_ff;
   status_type ns_ff;

   // scan control
   logic [CW-1:0] k_ff, k_in;           // issued reads
   logic [CW-1:0] done_ff, done_in;     // rows seen
   logic [IW-1:0] raddr_ff, raddr_in;   // next read address
   logic [IW-1:0] cur_ff, cur_in;       // address of row in rd_q
   logic [CW-1:0] wptr_ff, wptr_in;     // compaction write pointer
   logic pass2_ff, pass2_in;            // channel fallback pass
   logic found_ff, found_in;
   logic [LoadWidth-1:0] bload_ff, bload_in;
   logic [IdWidth-1:0] bid_ff, bid_in;

   logic [IdWidth-1:0] out_id_ff, out_id_in;
   code_type out_code_ff, out_code_in;

   logic we;
   logic [IW-1:0] waddr;
   entry_type wdata;
   logic avail;
   logic [TimeWidth-1:0] elapsed;
   logic [13:0] pc10, cap9;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata = {6'd0, out_code_ff, out_id_ff};

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_q <= mem[raddr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 2'd1;
         cap_ff <= 10'd1000;
         timeout_ff <= 16'd30;
         cpuovl_ff <= 7'd90;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_POLICY:   policy_ff <= csr_wdata[PolicyWidth-1:0];
            CSR_CAPACITY: cap_ff <= csr_wdata[LoadWidth-1:0];
            CSR_TIMEOUT:  timeout_ff <= csr_wdata[TimeoutWidth-1:0];
            CSR_CPU:      cpuovl_ff <= csr_wdata[CpuWidth-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rot_ff <= '0;
         time_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rot_ff <= rot_in;
         time_ff <= time_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff <= op_type'(req_tdata[2:0]);
         id_ff <= req_tdata[18:3];
         ch_ff <= req_tdata[26:19];
         pc_ff <= req_tdata[36:27];
         cpu_ff <= req_tdata[43:37];
         ns_ff <= status_type'(req_tdata[45:44]);
      end
      k_ff <= k_in;
      done_ff <= done_in;
      raddr_ff <= raddr_in;
      cur_ff <= cur_in;
      wptr_ff <= wptr_in;
      pass2_ff <= pass2_in;
      found_ff <= found_in;
      bload_ff <= bload_in;
      bid_ff <= bid_in;
      out_id_ff <= out_id_in;
      out_code_ff <= out_code_in;
   end

   assign avail = (rd_q.status == ST_ONLINE) && (rd_q.load < rd_q.capacity);
   assign elapsed = time_ff - rd_q.heartbeat;
   assign pc10 = {1'b0, pc_ff, 3'd0} + {3'd0, pc_ff, 1'b0};
   assign cap9 = {1'b0, rd_q.capacity, 3'd0} + {4'd0, rd_q.capacity};

   function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a, input logic [CW-1:0] n);
      logic [CW:0] s;
      s = {{(CW+1-IW){1'b0}}, a} + 1'b1;
      if (s >= {1'b0, n}) begin
         wrap_inc = '0;
      end else begin
         wrap_inc = s[IW-1:0];
      end
   endfunction

   always_comb begin
      logic hit;
      logic last;
      state_in = state_ff;
      count_in = count_ff;
      rot_in = rot_ff;
      time_in = time_ff;
      k_in = k_ff;
      done_in = done_ff;
      raddr_in = raddr_ff;
      cur_in = cur_ff;
      wptr_in = wptr_ff;
      pass2_in = pass2_ff;
      found_in = found_ff;
      bload_in = bload_ff;
      bid_in = bid_ff;
      out_id_in = out_id_ff;
      out_code_in = out_code_ff;
      we = 1'b0;
      waddr = cur_ff;
      wdata = rd_q;
      hit = 1'b0;
      last = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            // set up the walk
            k_in = '0;
            done_in = '0;
            wptr_in = '0;
            pass2_in = 1'b0;
            found_in = 1'b0;
            bload_in = '0;
            bid_in = '0;
            if (op_ff == OP_TICK) begin
               time_in = time_ff + 1'b1;
            end
            if (op_ff == OP_SELECT && policy_ff == POL_ROUND_ROBIN) begin
               raddr_in = rot_ff;
            end else begin
               raddr_in = '0;
            end
            if (op_ff == OP_REGISTER) begin
               state_in = S_FIN;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (k_ff > done_ff) begin
               // row at cur_ff is in rd_q
               done_in = done_ff + 1'b1;
               last = (done_ff + 1'b1 == count_ff);
               unique case (op_ff)
                  OP_SELECT: begin
                     if (policy_ff == POL_ROUND_ROBIN) begin
                        if (avail && !found_ff) begin
                           found_in = 1'b1;
                           bid_in = rd_q.srv_id;
                           rot_in = wrap_inc(cur_ff, count_ff);
                           hit = 1'b1;
                        end
                     end else begin
                        if (avail && (pass2_ff || policy_ff != POL_CHANNEL
                                      || rd_q.channel == ch_ff)
                            && (!found_ff || rd_q.load < bload_ff)) begin
                           found_in = 1'b1;
                           bload_in = rd_q.load;
                           bid_in = rd_q.srv_id;
                        end
                     end
                  end
                  OP_UNREGISTER: begin
                     if (rd_q.srv_id == id_ff) begin
                        found_in = 1'b1;
                     end else begin
                        we = 1'b1;
                        waddr = wptr_ff[IW-1:0];
                        wptr_in = wptr_ff + 1'b1;
                     end
                  end
                  OP_TICK: begin
                     if ((rd_q.status == ST_ONLINE || rd_q.status == ST_OVERLOADED)
                         && elapsed > {16'd0, timeout_ff}) begin
                        we = 1'b1;
                        wdata.status = ST_OFFLINE;
                     end
                  end
                  default: begin
                     // lookup by id, first match
                     if (rd_q.srv_id == id_ff) begin
                        hit = 1'b1;
                        found_in = 1'b1;
                        unique case (op_ff)
                           OP_UPDATE: begin
                              we = 1'b1;
                              wdata.load = pc_ff;
                              wdata.heartbeat = time_ff;
                              if (pc10 >= cap9 || cpu_ff >= cpuovl_ff) begin
                                 wdata.status = ST_OVERLOADED;
                              end else if (rd_q.status == ST_OVERLOADED) begin
                                 wdata.status = ST_ONLINE;
                              end
                           end
                           OP_SET_STATUS: begin
                              we = 1'b1;
                              wdata.status = ns_ff;
                           end
                           OP_ASSIGN: begin
                              we = avail;
                              found_in = avail;
                              wdata.load = rd_q.load + 1'b1;
                           end
                           OP_RELEASE: begin
                              we = (rd_q.load != '0);
                              wdata.load = rd_q.load - 1'b1;
                           end
                           default: ;
                        endcase
                     end
                  end
               endcase
               if (hit || last) begin
                  if (!hit && op_ff == OP_SELECT && policy_ff == POL_CHANNEL
                      && !pass2_ff && !found_in) begin
                     // restart as plain least loaded
                     pass2_in = 1'b1;
                     k_in = '0;
                     done_in = '0;
                     raddr_in = '0;
                  end else begin
                     state_in = S_FIN;
                  end
               end else if (k_ff < count_ff) begin
                  cur_in = raddr_ff;
                  raddr_in = wrap_inc(raddr_ff, count_ff);
                  k_in = k_ff + 1'b1;
               end
            end else if (count_ff == '0) begin
               state_in = S_FIN;
            end else if (CW'(raddr_ff) >= count_ff) begin
               // fold a rotation start left past the end back into the table
               raddr_in = raddr_ff - count_ff[IW-1:0];
            end else begin
               // first read issue
               cur_in = raddr_ff;
               raddr_in = wrap_inc(raddr_ff, count_ff);
               k_in = k_ff + 1'b1;
            end
         end
         S_FIN: begin
            out_id_in = '0;
            out_code_in = RC_OK;
            unique case (op_ff)
               OP_SELECT: begin
                  if (found_ff) begin
                     out_id_in = bid_ff;
                  end else begin
                     out_code_in = RC_NONE;
                  end
               end
               OP_REGISTER: begin
                  if (count_ff >= CW'(TABLE_SLOTS)) begin
                     out_code_in = RC_FULL;
                  end else begin
                     we = 1'b1;
                     waddr = count_ff[IW-1:0];
                     wdata.srv_id = id_ff;
                     wdata.channel = ch_ff;
                     wdata.status = ST_ONLINE;
                     wdata.load = '0;
                     wdata.capacity = cap_ff;
                     wdata.heartbeat = time_ff;
                     count_in = count_ff + 1'b1;
                  end
               end
               OP_UNREGISTER: begin
                  if (!found_ff) begin
                     out_code_in = RC_NONE;
                  end
                  count_in = wptr_ff;
               end
               OP_TICK: ;
               default: begin
                  if (!found_ff) begin
                     out_code_in = RC_NONE;
                  end
               end
            endcase
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench of the server table load balancer: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;
   import stlb_pkg::*;

   localparam int Slots = 16;
   localparam int CycleLimit = 600000;

   typedef struct {
      logic [15:0] chosen;
      code_type    code;
   } reply_type;

   typedef struct {
      logic [47:0] beat;
      bit          fixed;
      logic [15:0] chosen;
      code_type    code;
   } row_type;

   typedef struct {
      logic [1:0]  policy;
      logic [9:0]  capacity;
      logic [15:0] timeout;
      logic [6:0]  cpu;
   } setting_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_wen = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   server_table_load_balancer_core #(.TABLE_SLOTS(Slots)) uut (.*);

   // shadow of the table and the registers
   logic [1:0]  sh_policy = 2'd1;
   logic [9:0]  sh_capacity = 10'd1000;
   logic [15:0] sh_timeout = 16'd30;
   logic [6:0]  sh_cpu = 7'd90;
   int          sh_count;
   logic [15:0] sh_id [Slots];
   logic [7:0]  sh_chan [Slots];
   status_type  sh_status [Slots];
   logic [9:0]  sh_load [Slots];
   logic [9:0]  sh_cap [Slots];
   logic [31:0] sh_beat [Slots];
   int          sh_rot;
   logic [31:0] sh_now;

   reply_type   pending_replies[$];
   row_type     directed_rows[$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          burst_left;
   logic [15:0] id_pool [8] = '{16'h0000, 16'h0001, 16'h0002, 16'h0003,
                                16'hFFFF, 16'h8000, 16'h00FF, 16'h5A5A};

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bit available(int i);
      return sh_status[i] == ST_ONLINE && sh_load[i] < sh_cap[i];
   endfunction

   function automatic int find_server(logic [15:0] id);
      for (int i = 0; i < sh_count; i++)
         if (sh_id[i] == id) return i;
      return -1;
   endfunction

   function automatic int lightest(bit only_chan, logic [7:0] ch);
      int best;
      best = -1;
      for (int i = 0; i < sh_count; i++) begin
         if (only_chan && sh_chan[i] != ch) continue;
         if (!available(i)) continue;
         if (best < 0 || sh_load[i] < sh_load[best]) best = i;
      end
      return best;
   endfunction

   function automatic int next_in_rotation();
      int idx;
      for (int k = 0; k < sh_count; k++) begin
         idx = (sh_rot + k) % sh_count;
         if (available(idx)) begin
            sh_rot = (idx + 1) % sh_count;
            return idx;
         end
      end
      return -1;
   endfunction

   // apply one request to the shadow table and return the reply it earns
   function automatic reply_type serve_request(logic [47:0] beat);
      op_type      op;
      logic [15:0] id;
      logic [7:0]  ch;
      logic [9:0]  pc;
      logic [6:0]  cpu;
      int          e;
      int          w;
      reply_type   r;
      op = op_type'(beat[2:0]);
      id = beat[18:3];
      ch = beat[26:19];
      pc = beat[36:27];
      cpu = beat[43:37];
      r.chosen = '0;
      r.code = RC_OK;
      case (op)
         OP_SELECT: begin
            if (sh_policy == POL_ROUND_ROBIN) e = next_in_rotation();
            else if (sh_policy == POL_CHANNEL) begin
               e = lightest(1'b1, ch);
               if (e < 0) e = lightest(1'b0, '0);
            end else e = lightest(1'b0, '0);
            if (e < 0) r.code = RC_NONE;
            else r.chosen = sh_id[e];
         end
         OP_REGISTER: begin
            if (sh_count >= Slots) r.code = RC_FULL;
            else begin
               sh_id[sh_count] = id;
               sh_chan[sh_count] = ch;
               sh_status[sh_count] = ST_ONLINE;
               sh_load[sh_count] = '0;
               sh_cap[sh_count] = sh_capacity;
               sh_beat[sh_count] = sh_now;
               sh_count++;
            end
         end
         OP_UNREGISTER: begin
            w = 0;
            for (int i = 0; i < sh_count; i++) begin
               if (sh_id[i] == id) continue;
               sh_id[w] = sh_id[i];
               sh_chan[w] = sh_chan[i];
               sh_status[w] = sh_status[i];
               sh_load[w] = sh_load[i];
               sh_cap[w] = sh_cap[i];
               sh_beat[w] = sh_beat[i];
               w++;
            end
            if (w == sh_count) r.code = RC_NONE;
            sh_count = w;
         end
         OP_UPDATE: begin
            e = find_server(id);
            if (e < 0) r.code = RC_NONE;
            else begin
               sh_load[e] = pc;
               sh_beat[e] = sh_now;
               if (int'(pc) * 10 >= int'(sh_cap[e]) * 9 || cpu >= sh_cpu)
                  sh_status[e] = ST_OVERLOADED;
               else if (sh_status[e] == ST_OVERLOADED)
                  sh_status[e] = ST_ONLINE;
            end
         end
         OP_SET_STATUS: begin
            e = find_server(id);
            if (e < 0) r.code = RC_NONE;
            else sh_status[e] = status_type'(beat[45:44]);
         end
         OP_ASSIGN: begin
            e = find_server(id);
            if (e < 0 || !available(e)) r.code = RC_NONE;
            else sh_load[e] = sh_load[e] + 10'd1;
         end
         OP_RELEASE: begin
            e = find_server(id);
            if (e < 0) r.code = RC_NONE;
            else if (sh_load[e] > 0) sh_load[e] = sh_load[e] - 10'd1;
         end
         default: begin
            sh_now = sh_now + 32'd1;
            for (int i = 0; i < sh_count; i++)
               if ((sh_status[i] == ST_ONLINE || sh_status[i] == ST_OVERLOADED) &&
                   (sh_now - sh_beat[i]) > {16'd0, sh_timeout})
                  sh_status[i] = ST_OFFLINE;
         end
      endcase
      return r;
   endfunction

   function automatic logic [47:0] pack_req(op_type op, logic [15:0] id, logic [7:0] ch,
                                            logic [9:0] pc, logic [6:0] cpu, logic [1:0] ns);
      return {2'b00, ns, cpu, pc, ch, id, op};
   endfunction

   function automatic void add_row(op_type op, logic [15:0] id, logic [7:0] ch, logic [9:0] pc,
                                   logic [6:0] cpu, logic [1:0] ns, bit fixed,
                                   logic [15:0] chosen, code_type code);
      row_type r;
      r.beat = pack_req(op, id, ch, pc, cpu, ns);
      r.fixed = fixed;
      r.chosen = chosen;
      r.code = code;
      directed_rows = {directed_rows, r};
   endfunction

   // present one beat, keeping valid high inside a burst
   task automatic send_request(logic [47:0] beat, bit fixed, logic [15:0] chosen,
                               code_type code);
      int        gap;
      reply_type r;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid <= 1'b1;
      req_tdata <= beat;
      burst_left--;
      do @(posedge clock); while (!req_tready);
      r = serve_request(beat);
      if (fixed) begin
         r.chosen = chosen;
         r.code = code;
      end
      pending_replies = {pending_replies, r};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   task automatic write_settings(setting_type s);
      csr_wen <= 1'b1;
      csr_index <= CSR_POLICY;
      csr_wdata <= {14'd0, s.policy};
      @(posedge clock);
      csr_index <= CSR_CAPACITY;
      csr_wdata <= {6'd0, s.capacity};
      @(posedge clock);
      csr_index <= CSR_TIMEOUT;
      csr_wdata <= s.timeout;
      @(posedge clock);
      csr_index <= CSR_CPU;
      csr_wdata <= {9'd0, s.cpu};
      @(posedge clock);
      csr_wen <= 1'b0;
      sh_policy = s.policy;
      sh_capacity = s.capacity;
      sh_timeout = s.timeout;
      sh_cpu = s.cpu;
   endtask

   function automatic logic [15:0] pick_id();
      return $urandom_range(0, 9) == 0 ? 16'($urandom) : id_pool[$urandom_range(0, 7)];
   endfunction

   // receive side: check each reply beat, stall on a pattern set by bits 9:8 of the cycle counter
   always @(posedge clock) begin : reply_check
      reply_type x;
      int        stall_pct;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected reply beat %h", rsp_tdata);
            end else begin
               x = pending_replies.pop_front();
               if (rsp_tdata[15:0] !== x.chosen || rsp_tdata[17:16] !== x.code) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("reply mismatch: expected server %h code %s, got server %h code %0d",
                              x.chosen, x.code.name(), rsp_tdata[15:0], rsp_tdata[17:16]);
               end
            end
         end
         case (cycle_count[9:8])
            2'd0: stall_pct = 0;
            2'd1: stall_pct = 30;
            2'd2: stall_pct = 75;
            default: stall_pct = 10;
         endcase
         rsp_tready <= $urandom_range(0, 99) >= stall_pct;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : stimulus
      setting_type phases [6];
      logic [47:0] beat;
      logic [9:0]  pc;
      int          r;
      op_type      op;
      sh_count = 0;
      sh_rot = 0;
      sh_now = '0;
      burst_left = 0;
      phases = '{'{2'd0, 10'd1000, 16'd30, 7'd90}, '{2'd2, 10'd1, 16'd1, 7'd0},
                 '{2'd1, 10'd1023, 16'd65535, 7'd100}, '{2'd3, 10'd0, 16'd5, 7'd127},
                 '{2'd2, 10'd20, 16'd8, 7'd50}, '{2'd0, 10'd10, 16'd3, 7'd100}};

      // empty table, extremes of id and channel, threshold and status cases
      add_row(OP_SELECT, 16'h0001, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_UNREGISTER, 16'h0005, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_UPDATE, 16'h0005, 8'h00, 10'd5, 7'd5, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_ASSIGN, 16'h0005, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_RELEASE, 16'h0005, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_SET_STATUS, 16'h0005, 8'h00, '0, '0, 2'd2, 1, 16'h0000, RC_NONE);
      add_row(OP_REGISTER, 16'hFFFF, 8'hFF, '0, '0, 2'd0, 1, 16'h0000, RC_OK);
      add_row(OP_REGISTER, 16'h0000, 8'h00, 10'h3FF, 7'h7F, 2'd3, 1, 16'h0000, RC_OK);
      add_row(OP_REGISTER, 16'h1234, 8'h07, '0, '0, 2'd0, 1, 16'h0000, RC_OK);
      add_row(OP_SELECT, 16'h0000, 8'h00, '0, '0, 2'd0, 1, 16'hFFFF, RC_OK);
      add_row(OP_ASSIGN, 16'hFFFF, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_OK);
      add_row(OP_SELECT, 16'h0000, 8'h00, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_UPDATE, 16'h1234, 8'h00, 10'd900, 7'd0, 2'd0, 0, '0, RC_OK);
      add_row(OP_UPDATE, 16'h0000, 8'h00, 10'd0, 7'd100, 2'd0, 0, '0, RC_OK);
      add_row(OP_SELECT, 16'h0000, 8'h00, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_UPDATE, 16'h1234, 8'h00, 10'd899, 7'd89, 2'd0, 0, '0, RC_OK);
      add_row(OP_RELEASE, 16'h0000, 8'h00, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_UPDATE, 16'h0000, 8'h00, 10'd1023, 7'd0, 2'd0, 0, '0, RC_OK);
      add_row(OP_SET_STATUS, 16'hFFFF, 8'h00, '0, '0, 2'd2, 0, '0, RC_OK);
      add_row(OP_ASSIGN, 16'hFFFF, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_NONE);
      add_row(OP_TICK, 16'h0000, 8'h00, '0, '0, 2'd0, 1, 16'h0000, RC_OK);
      add_row(OP_REGISTER, 16'h1234, 8'h07, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_SELECT, 16'h0000, 8'h07, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_UNREGISTER, 16'h1234, 8'h00, '0, '0, 2'd0, 0, '0, RC_OK);
      add_row(OP_SET_STATUS, 16'h0000, 8'h00, '0, '0, 2'd1, 0, '0, RC_OK);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_rows[i])
         send_request(directed_rows[i].beat, directed_rows[i].fixed,
                      directed_rows[i].chosen, directed_rows[i].code);

      foreach (phases[p]) begin
         drain();
         write_settings(phases[p]);
         for (int n = 0; n < 100; n++) begin
            // open each phase by filling the table past full
            r = n < 18 ? 0 : $urandom_range(0, 99);
            if (r < 22) op = OP_REGISTER;
            else if (r < 30) op = OP_UNREGISTER;
            else if (r < 42) op = OP_UPDATE;
            else if (r < 50) op = OP_SET_STATUS;
            else if (r < 62) op = OP_ASSIGN;
            else if (r < 68) op = OP_RELEASE;
            else if (r < 78) op = OP_TICK;
            else op = OP_SELECT;
            if ($urandom_range(0, 1)) pc = 10'($urandom_range(0, 1023));
            else begin
               r = int'(sh_capacity) * 9 / 10 + $urandom_range(0, 4) - 2;
               pc = r < 0 ? 10'd0 : (r > 1023 ? 10'd1023 : 10'(r));
            end
            beat = pack_req(op, pick_id(),
                            $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                            pc, 7'($urandom_range(0, 100)), 2'($urandom_range(0, 3)));
            send_request(beat, 1'b0, '0, RC_OK);
         end
      end

      drain();
      repeat (60) @(posedge clock);
      if (mismatches == 0 && pending_replies.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: sim.f
design/stlb_pkg.sv
design/server_table_load_balancer_core.sv
tb/tb_top.sv
